// ----- sv/mosa_pkg.sv -----
// Shared types and constants for the median of two sorted lists block.
// No dependencies; imported by median_of_two_sorted_arrays.
package mosa_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int MEDIAN_W = 33;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_CMP,
        S_PICK,
        S_DONE
    } state_t;

    // What the current selection step does with the read data
    typedef enum logic [1:0] {
        SEL_TAKE_A,
        SEL_TAKE_B,
        SEL_TAKE_MIN,
        SEL_HALVE
    } sel_kind_t;

endpackage

// ----- sv/median_of_two_sorted_arrays.sv -----
// Top level: two list memories, the k-th element selection sequencer and the
// result register. Depends on mosa_pkg.
//
// Loads (cmd 0 to list A, cmd 1 to list B) are taken one per cycle while the
// block is idle; a load into a full list is dropped and marks the next result
// with the overflow status. A compute (cmd 2) holds stall high while the
// sequencer runs: a start state, then per selection pass the halving steps,
// each a check state (one registered read of both memories) and a compare
// state, then a check and a pick state for the final read; an odd total runs
// one pass, an even total two, an empty set none. The done state moves the
// answer to the output register and waits while the previous result there is
// still waiting; that register may be waiting to be taken while new loads come
// in. The answer is twice the median (33-bit signed); both lists and the
// overflow mark are cleared afterwards. Unused command code 3 is ignored.
module median_of_two_sorted_arrays
    import mosa_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [MEDIAN_W-1:0] median_twice,
    output logic [STATUS_W-1:0]        status
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int K_W   = $clog2(2 * MAX_LEN + 1) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    // List storage
    logic signed [VALUE_W-1:0] list_a [0:MAX_LEN-1];
    logic signed [VALUE_W-1:0] list_b [0:MAX_LEN-1];
    logic signed [VALUE_W-1:0] a_rd_reg;
    logic signed [VALUE_W-1:0] b_rd_reg;
    logic [IDX_W-1:0]          addr_a;
    logic [IDX_W-1:0]          addr_b;
    logic                      we_a;
    logic                      we_b;

    // Control and datapath registers
    state_t                    state_reg, state_next;
    sel_kind_t                 kind_reg, kind_next;
    logic [CNT_W-1:0]          count_a_reg, count_a_next;
    logic [CNT_W-1:0]          count_b_reg, count_b_next;
    logic                      overflow_reg, overflow_next;
    logic [CNT_W-1:0]          i_reg, i_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [CNT_W-1:0]          pa_reg, pa_next;
    logic [CNT_W-1:0]          pb_reg, pb_next;
    logic                      second_reg, second_next;
    logic signed [MEDIAN_W-1:0] acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [MEDIAN_W-1:0] median_reg, median_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    // Derived values
    logic                      accept;
    logic                      out_free;
    logic [K_W-1:0]            total;
    logic                      odd_total;
    logic                      a_done;
    logic                      b_done;
    logic [K_W-1:0]            pa_w;
    logic [K_W-1:0]            pb_w;
    logic [K_W-1:0]            na_m1;
    logic [K_W-1:0]            nb_m1;
    logic [K_W-1:0]            pa_c;
    logic [K_W-1:0]            pb_c;
    logic [K_W-1:0]            term_a;
    logic [K_W-1:0]            term_b;
    logic signed [VALUE_W-1:0] pick;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign total     = K_W'(count_a_reg) + K_W'(count_b_reg);
    assign odd_total = total[0];
    assign a_done    = i_reg >= count_a_reg;
    assign b_done    = j_reg >= count_b_reg;

    // Halving probe positions, clamped to the last stored element
    assign na_m1  = K_W'(count_a_reg) - K_W'(1);
    assign nb_m1  = K_W'(count_b_reg) - K_W'(1);
    assign pa_w   = K_W'(i_reg) + (k_reg >> 1) - K_W'(1);
    assign pb_w   = K_W'(j_reg) + (k_reg >> 1) - K_W'(1);
    assign pa_c   = (pa_w > na_m1) ? na_m1 : pa_w;
    assign pb_c   = (pb_w > nb_m1) ? nb_m1 : pb_w;
    assign term_a = K_W'(i_reg) + k_reg - K_W'(1);
    assign term_b = K_W'(j_reg) + k_reg - K_W'(1);

    // Read addresses, meaningful in the check state
    always_comb
    begin
        if (b_done)
        begin
            addr_a = term_a[IDX_W-1:0];
        end
        else if (k_reg == K_W'(1))
        begin
            addr_a = i_reg[IDX_W-1:0];
        end
        else
        begin
            addr_a = pa_c[IDX_W-1:0];
        end
        if (a_done)
        begin
            addr_b = term_b[IDX_W-1:0];
        end
        else if (k_reg == K_W'(1))
        begin
            addr_b = j_reg[IDX_W-1:0];
        end
        else
        begin
            addr_b = pb_c[IDX_W-1:0];
        end
    end

    assign we_a = accept && (cmd == CMD_LOAD_A) && (count_a_reg < MAX_CNT);
    assign we_b = accept && (cmd == CMD_LOAD_B) && (count_b_reg < MAX_CNT);

    // Memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            list_a[count_a_reg[IDX_W-1:0]] <= value;
        end
        a_rd_reg <= list_a[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            list_b[count_b_reg[IDX_W-1:0]] <= value;
        end
        b_rd_reg <= list_b[addr_b];
    end

    // Element chosen at the end of a selection pass
    always_comb
    begin
        case (kind_reg)
            SEL_TAKE_A: pick = a_rd_reg;
            SEL_TAKE_B: pick = b_rd_reg;
            default:    pick = (a_rd_reg < b_rd_reg) ? a_rd_reg : b_rd_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_COMPUTE))
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (total == '0) ? S_DONE : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (a_done || b_done || (k_reg == K_W'(1))) ? S_PICK : S_CMP;
            end
            S_CMP:
            begin
                state_next = S_CHECK;
            end
            S_PICK:
            begin
                state_next = (!second_reg && !odd_total) ? S_CHECK : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        overflow_next  = overflow_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        kind_next      = kind_reg;
        second_next    = second_reg;
        acc_next       = acc_reg;
        median_next    = median_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = state_reg != S_IDLE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_LOAD_A))
                begin
                    if (count_a_reg < MAX_CNT)
                    begin
                        count_a_next = count_a_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                if (accept && (cmd == CMD_LOAD_B))
                begin
                    if (count_b_reg < MAX_CNT)
                    begin
                        count_b_next = count_b_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            S_START:
            begin
                i_next      = '0;
                j_next      = '0;
                k_next      = (total + K_W'(1)) >> 1;
                second_next = 1'b0;
                acc_next    = '0;
            end
            S_CHECK:
            begin
                pa_next = pa_c[CNT_W-1:0];
                pb_next = pb_c[CNT_W-1:0];
                if (a_done)
                begin
                    kind_next = SEL_TAKE_B;
                end
                else if (b_done)
                begin
                    kind_next = SEL_TAKE_A;
                end
                else if (k_reg == K_W'(1))
                begin
                    kind_next = SEL_TAKE_MIN;
                end
                else
                begin
                    kind_next = SEL_HALVE;
                end
            end
            S_CMP:
            begin
                // drop the smaller probe's prefix
                if (a_rd_reg <= b_rd_reg)
                begin
                    k_next = k_reg - (K_W'(pa_reg) - K_W'(i_reg) + K_W'(1));
                    i_next = pa_reg + CNT_W'(1);
                end
                else
                begin
                    k_next = k_reg - (K_W'(pb_reg) - K_W'(j_reg) + K_W'(1));
                    j_next = pb_reg + CNT_W'(1);
                end
            end
            S_PICK:
            begin
                if (second_reg)
                begin
                    acc_next = acc_reg + MEDIAN_W'(pick);
                end
                else if (odd_total)
                begin
                    acc_next = {pick, 1'b0};
                end
                else
                begin
                    // even total: select the upper middle next
                    acc_next    = MEDIAN_W'(pick);
                    second_next = 1'b1;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = (total >> 1) + K_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    median_next    = acc_reg;
                    if (overflow_reg)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else if (total == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                    end
                    count_a_next  = '0;
                    count_b_next  = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        kind_reg   <= kind_next;
        second_reg <= second_next;
        acc_reg    <= acc_next;
        median_reg <= median_next;
        status_reg <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;
    assign status       = status_reg;

endmodule

// ----- verif/median_of_two_sorted_arrays_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for median_of_two_sorted_arrays: random and directed
// list loads and median computes, checked against a predictor in a scoreboard.
// Depends on mosa_pkg and the median_of_two_sorted_arrays RTL.
module median_of_two_sorted_arrays_test
    import mosa_pkg::*;
();

    localparam int MAX_LEN      = 1024;
    localparam int ITEM_TARGET  = 1950;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    // Command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Value spreads for generated lists
    localparam int SPREAD_WIDE   = 0;
    localparam int SPREAD_NARROW = 1;
    localparam int SPREAD_TOP    = 2;
    localparam int SPREAD_BOTTOM = 3;

    typedef struct packed {
        logic [MEDIAN_W-1:0] median;
        logic [STATUS_W-1:0] status;
    } median_result_t;

    // Scoreboard: mirrors the stored lists and predicts each compute
    class median_scoreboard;
        logic signed [VALUE_W-1:0] store_a [MAX_LEN];
        logic signed [VALUE_W-1:0] store_b [MAX_LEN];
        int unsigned               fill_a;
        int unsigned               fill_b;
        bit                        lost_load;
        median_result_t            due_medians [$];
        int                        errors;

        function new();
            fill_a    = 0;
            fill_b    = 0;
            lost_load = 1'b0;
            errors    = 0;
        endfunction

        function longint read_list(bit from_b, int unsigned idx);
            if (from_b)
                return store_b[idx % MAX_LEN];
            return store_a[idx % MAX_LEN];
        endfunction

        // k-th smallest (k from 1) of both lists by halving elimination
        function longint kth_smallest(int unsigned k_first);
            int unsigned k;
            int unsigned i;
            int unsigned j;
            int unsigned pa;
            int unsigned pb;
            longint      x;
            longint      y;
            longint      pick;
            bit          done;
            k    = k_first;
            i    = 0;
            j    = 0;
            pick = 0;
            done = 1'b0;
            while (!done)
            begin
                if (k == 0)
                    k = 1;
                if (i >= fill_a)
                begin
                    pick = read_list(1'b1, j + k - 1);
                    done = 1'b1;
                end
                else if (j >= fill_b)
                begin
                    pick = read_list(1'b0, i + k - 1);
                    done = 1'b1;
                end
                else if (k == 1)
                begin
                    x    = read_list(1'b0, i);
                    y    = read_list(1'b1, j);
                    pick = (x < y) ? x : y;
                    done = 1'b1;
                end
                else
                begin
                    pa = i + k / 2 - 1;
                    pb = j + k / 2 - 1;
                    if (pa > fill_a - 1)
                        pa = fill_a - 1;
                    if (pb > fill_b - 1)
                        pb = fill_b - 1;
                    // discard the lower half on the side with the smaller probe
                    if (read_list(1'b0, pa) <= read_list(1'b1, pb))
                    begin
                        k = k - (pa - i + 1);
                        i = pa + 1;
                    end
                    else
                    begin
                        k = k - (pb - j + 1);
                        j = pb + 1;
                    end
                end
            end
            return pick;
        endfunction

        // Accepted input transfer: load, compute or ignore
        function void note_input(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v);
            int unsigned    total;
            longint         twice;
            median_result_t res;
            case (c)
                CMD_LOAD_A:
                begin
                    if (fill_a < MAX_LEN)
                    begin
                        store_a[fill_a] = v;
                        fill_a++;
                    end
                    else
                        lost_load = 1'b1;
                end
                CMD_LOAD_B:
                begin
                    if (fill_b < MAX_LEN)
                    begin
                        store_b[fill_b] = v;
                        fill_b++;
                    end
                    else
                        lost_load = 1'b1;
                end
                CMD_COMPUTE:
                begin
                    total = fill_a + fill_b;
                    twice = 0;
                    if (total == 0)
                        res.status = STATUS_EMPTY;
                    else
                    begin
                        if ((total % 2) == 1)
                            twice = 2 * kth_smallest((total + 1) / 2);
                        else
                            twice = kth_smallest(total / 2) + kth_smallest(total / 2 + 1);
                        res.status = STATUS_OK;
                    end
                    // overflow wins over the empty status
                    if (lost_load)
                        res.status = STATUS_OVERFLOW;
                    res.median = twice[MEDIAN_W-1:0];
                    due_medians.insert(due_medians.size(), res);
                    fill_a    = 0;
                    fill_b    = 0;
                    lost_load = 1'b0;
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        // Accepted output transfer against the oldest prediction
        task check_result(logic signed [MEDIAN_W-1:0] m, logic [STATUS_W-1:0] s);
            median_result_t want;
            if (due_medians.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result median_twice %0d status %0d",
                                          m, s));
                return;
            end
            want = due_medians.pop_front();
            if (m !== want.median)
                report_mismatch($sformatf("median_twice %0d, want %0d",
                                          m, $signed(want.median)));
            if (s !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", s, want.status));
        endtask

        function int pending();
            return due_medians.size();
        endfunction

        task check_drained();
            if (due_medians.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", due_medians.size()));
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [CMD_W-1:0]           cmd;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [MEDIAN_W-1:0] median_twice;
    logic [STATUS_W-1:0]        status;

    median_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      items_sent;
    bit               pressure_req;

    median_of_two_sorted_arrays #(
        .MAX_LEN      (MAX_LEN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_twice (median_twice),
        .status       (status)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watch both channels; inputs are noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(cmd, value);
            if (out_valid && !out_stall)
                sb.check_result(median_twice, status);
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int  hold_left;
        bit  hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic signed [VALUE_W-1:0] first_value(int unsigned spread);
        case (spread)
            SPREAD_NARROW: return $urandom_range(16, 0) - 8;
            SPREAD_TOP:    return 32'sh7fffffff - $urandom_range(40, 0);
            SPREAD_BOTTOM: return 32'sh80000000 + $urandom_range(40, 0);
            default:       return $urandom;
        endcase
    endfunction

    // Next element of an ascending list, saturating at the top
    function automatic logic signed [VALUE_W-1:0] next_value(logic signed [VALUE_W-1:0] prev,
                                                           int unsigned spread);
        longint nxt;
        nxt = prev;
        if (spread == SPREAD_WIDE)
            nxt = nxt + longint'($urandom_range(1 << 20, 0));
        else
            nxt = nxt + longint'($urandom_range(3, 0));
        if (nxt > 64'sd2147483647)
            nxt = 64'sd2147483647;
        return nxt[VALUE_W-1:0];
    endfunction

    // Load na elements into A and nb into B, interleaved, then compute
    task automatic send_set(input int unsigned na, input int unsigned nb,
                            input int unsigned spread, input bit sorted, input bit noisy);
        logic signed [VALUE_W-1:0] va;
        logic signed [VALUE_W-1:0] vb;
        int unsigned               ia;
        int unsigned               ib;
        bit                        take_b;
        va = first_value(spread);
        vb = first_value(spread);
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            take_b = (ia >= na) || (ib < nb && $urandom_range(1, 0) == 1);
            if (noisy && $urandom_range(5, 0) == 0)
                send_item(CMD_UNUSED, $urandom);
            if (take_b)
            begin
                send_item(CMD_LOAD_B, vb);
                ib++;
                vb = sorted ? next_value(vb, spread) : first_value(spread);
            end
            else
            begin
                send_item(CMD_LOAD_A, va);
                ia++;
                va = sorted ? next_value(va, spread) : first_value(spread);
            end
        end
        send_item(CMD_COMPUTE, $urandom);
    endtask

    // Main sequence
    initial
    begin
        int unsigned kind;
        int unsigned na;
        int unsigned nb;
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_LOAD_A;
        value         = '0;
        send_idle_pct = 16;
        recv_idle_pct = 16;
        items_sent    = 0;
        pressure_req  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty compute, ignored code, extremes, exhausted list B, unsorted
        send_item(CMD_COMPUTE, 32'sh12345678);
        send_item(CMD_UNUSED, 32'sh7fffffff);
        send_item(CMD_LOAD_A, 32'sh80000000);
        send_item(CMD_LOAD_B, 32'sh7fffffff);
        send_item(CMD_COMPUTE, '0);
        send_item(CMD_LOAD_A, 32'sh7fffffff);
        send_item(CMD_COMPUTE, '1);
        send_item(CMD_LOAD_B, 32'sh80000000);
        send_item(CMD_COMPUTE, '0);
        send_item(CMD_LOAD_A, 1);
        send_item(CMD_LOAD_B, 2);
        send_item(CMD_LOAD_A, 3);
        send_item(CMD_COMPUTE, '0);
        send_item(CMD_LOAD_A, 10);
        send_item(CMD_LOAD_B, 1);
        send_item(CMD_LOAD_A, 20);
        send_item(CMD_LOAD_A, 30);
        send_item(CMD_LOAD_B, 2);
        send_item(CMD_LOAD_A, 40);
        send_item(CMD_LOAD_A, 50);
        send_item(CMD_COMPUTE, '0);
        send_item(CMD_LOAD_A, 5);
        send_item(CMD_LOAD_A, 1);
        send_item(CMD_LOAD_B, 3);
        send_item(CMD_COMPUTE, '0);

        // Fill list A past capacity with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_set(MAX_LEN + 2, 3, SPREAD_WIDE, 1'b1, 1'b0);

        // Random sets; the receiver holds off once early on
        send_idle_pct = 16;
        recv_idle_pct = 16;
        pressure_req  = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(99, 0);
            if ($urandom_range(19, 0) == 0)
            begin
                na = $urandom_range(40, 0);
                nb = $urandom_range(40, 0);
            end
            else if ($urandom_range(24, 0) == 0)
            begin
                na = 0;
                nb = 0;
            end
            else
            begin
                na = $urandom_range(10, 0);
                nb = $urandom_range(10, 0);
            end
            if (kind < 78)
                send_set(na, nb, $urandom_range(3, 0), 1'b1, 1'b0);
            else if (kind < 90)
                send_set(na, nb, $urandom_range(3, 0), 1'b0, 1'b0);
            else
                send_set(na, nb, $urandom_range(3, 0), $urandom_range(1, 0), 1'b1);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then allow for any trailing output
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
